// ===== hdl/bas_pkg.sv =====
`timescale 1ns / 1ps

package bas_pkg;

    // operation selector width
    localparam int FUNC_W = 2;

    // operation codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } t_func;

endpackage

// ===== hdl/bas_step.sv =====
`timescale 1ns / 1ps

// one pipeline stage: one shift-add multiply step and one restoring divide step
module bas_step import bas_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int STEP  = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_func              i_func,
    input  logic [WIDTH-1:0]   i_a,
    input  logic [WIDTH-1:0]   i_b,
    input  logic [2*WIDTH-1:0] i_acc,
    input  logic [WIDTH-1:0]   i_rem,
    input  logic [WIDTH-1:0]   i_quo,
    output logic               o_valid,
    input  logic               i_ready,
    output t_func              o_func,
    output logic [WIDTH-1:0]   o_a,
    output logic [WIDTH-1:0]   o_b,
    output logic [2*WIDTH-1:0] o_acc,
    output logic [WIDTH-1:0]   o_rem,
    output logic [WIDTH-1:0]   o_quo
);

    logic               r_valid;
    t_func              r_func;
    logic [WIDTH-1:0]   r_a;
    logic [WIDTH-1:0]   r_b;
    logic [2*WIDTH-1:0] r_acc;
    logic [WIDTH-1:0]   r_rem;
    logic [WIDTH-1:0]   r_quo;

    logic [2*WIDTH-1:0] n_acc;
    logic [WIDTH-1:0]   n_rem;
    logic [WIDTH-1:0]   n_quo;
    logic [WIDTH:0]     w_part;
    logic [WIDTH:0]     w_diff;
    logic               w_ge;

    // stage can take a beat when empty or when its content moves on
    assign o_ready = !r_valid || i_ready;

    // multiply: add the shifted multiplicand when this multiplier bit is set
    always_comb begin
        n_acc = i_acc;
        if (i_a[STEP]) begin
            n_acc = i_acc + ({{WIDTH{1'b0}}, i_b} << STEP);
        end
    end

    // divide: bring down the next dividend bit, subtract when it fits
    always_comb begin
        w_part = {i_rem, i_a[WIDTH-1-STEP]};
        w_diff = w_part - {1'b0, i_b};
        w_ge   = (w_part >= {1'b0, i_b});
        n_rem  = w_ge ? w_diff[WIDTH-1:0] : w_part[WIDTH-1:0];
        n_quo  = {i_quo[WIDTH-2:0], w_ge};
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_func <= i_func;
            r_a    <= i_a;
            r_b    <= i_b;
            r_acc  <= n_acc;
            r_rem  <= n_rem;
            r_quo  <= n_quo;
        end
    end

    assign o_valid = r_valid;
    assign o_func  = r_func;
    assign o_a     = r_a;
    assign o_b     = r_b;
    assign o_acc   = r_acc;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;

endmodule

// ===== hdl/byte_add_sub_mul_div_unit_top.sv =====
`timescale 1ns / 1ps

// Unsigned arithmetic unit on two WIDTH-bit operands: add, subtract (wrapping),
// shift-add multiply (product split over result low and high) and restoring
// divide (quotient low, remainder high). A zero divisor raises div_by_zero and
// gives an all-ones quotient with the remainder equal to the dividend. One beat
// is taken every cycle unless backpressure stalls the chain; each beat passes
// WIDTH step stages (one multiply step and one divide step each) plus an output
// register. Every stage holds its beat under backpressure and bubbles close up.
module byte_add_sub_mul_div_unit_top import bas_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // operand_a, operand_b, zero pad
    input  logic [((2*WIDTH+7)/8)*8-1:0]      s_axis_tdata,
    // func
    input  logic [FUNC_W-1:0]                 s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // result_low, result_high, zero pad
    output logic [((2*WIDTH+7)/8)*8-1:0]      m_axis_tdata,
    // div_by_zero
    output logic                              m_axis_tuser
);

    localparam int OUT_W = ((2*WIDTH+7)/8)*8;

    // step chain, index 0 is the input side
    logic               w_valid [0:WIDTH];
    logic               w_ready [0:WIDTH];
    t_func              w_func  [0:WIDTH];
    logic [WIDTH-1:0]   w_a     [0:WIDTH];
    logic [WIDTH-1:0]   w_b     [0:WIDTH];
    logic [2*WIDTH-1:0] w_acc   [0:WIDTH];
    logic [WIDTH-1:0]   w_rem   [0:WIDTH];
    logic [WIDTH-1:0]   w_quo   [0:WIDTH];

    logic               r_out_valid;
    logic [WIDTH-1:0]   r_lo;
    logic [WIDTH-1:0]   r_hi;
    logic               r_dz;
    logic [WIDTH-1:0]   n_lo;
    logic [WIDTH-1:0]   n_hi;
    logic               n_dz;

    // input beat enters the first step stage
    assign w_valid[0]    = s_axis_tvalid;
    assign s_axis_tready = w_ready[0];
    assign w_func[0]     = t_func'(s_axis_tuser);
    assign w_a[0]        = s_axis_tdata[WIDTH-1:0];
    assign w_b[0]        = s_axis_tdata[2*WIDTH-1:WIDTH];
    assign w_acc[0]      = '0;
    assign w_rem[0]      = '0;
    assign w_quo[0]      = '0;

    genvar k;
    generate
        for (k = 0; k < WIDTH; k++) begin : g_step
            bas_step #(
                .WIDTH (WIDTH),
                .STEP  (k)
            ) u_step (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (w_valid[k]),
                .o_ready (w_ready[k]),
                .i_func  (w_func[k]),
                .i_a     (w_a[k]),
                .i_b     (w_b[k]),
                .i_acc   (w_acc[k]),
                .i_rem   (w_rem[k]),
                .i_quo   (w_quo[k]),
                .o_valid (w_valid[k+1]),
                .i_ready (w_ready[k+1]),
                .o_func  (w_func[k+1]),
                .o_a     (w_a[k+1]),
                .o_b     (w_b[k+1]),
                .o_acc   (w_acc[k+1]),
                .o_rem   (w_rem[k+1]),
                .o_quo   (w_quo[k+1])
            );
        end
    endgenerate

    // output register takes a beat when empty or when the sink takes its beat
    assign w_ready[WIDTH] = !r_out_valid || m_axis_tready;

    // result select
    always_comb begin
        n_lo = '0;
        n_hi = '0;
        n_dz = 1'b0;
        case (w_func[WIDTH])
            FUNC_ADD: begin
                n_lo = w_a[WIDTH] + w_b[WIDTH];
            end
            FUNC_SUB: begin
                n_lo = w_a[WIDTH] - w_b[WIDTH];
            end
            FUNC_MUL: begin
                n_lo = w_acc[WIDTH][WIDTH-1:0];
                n_hi = w_acc[WIDTH][2*WIDTH-1:WIDTH];
            end
            default: begin
                n_lo = w_quo[WIDTH];
                n_hi = w_rem[WIDTH];
                n_dz = (w_b[WIDTH] == '0);
            end
        endcase
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ready[WIDTH]) begin
            r_out_valid <= w_valid[WIDTH];
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_ready[WIDTH] && w_valid[WIDTH]) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
            r_dz <= n_dz;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_hi, r_lo});
    assign m_axis_tuser  = r_dz;

endmodule

// ===== test/byte_add_sub_mul_div_unit_top_tb.sv =====
`timescale 1ns / 1ps

module byte_add_sub_mul_div_unit_top_tb;
    import bas_pkg::*;

    localparam int WIDTH       = 8;
    localparam int DATA_W      = ((2*WIDTH+7)/8)*8;
    localparam int LATENCY     = WIDTH + 1;
    localparam int STALL_LIMIT = 5000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [WIDTH-1:0] lo;
        logic [WIDTH-1:0] hi;
        logic             dz;
    } t_arith_res;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata;   // operand_a, operand_b, zero pad
    logic [FUNC_W-1:0] s_axis_tuser;   // func
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [DATA_W-1:0] m_axis_tdata;   // result_low, result_high, zero pad
    logic              m_axis_tuser;   // div_by_zero

    t_arith_res expected_results[$];
    int pending       = 0;
    int mismatches    = 0;
    int results_seen  = 0;
    int beats_in      = 0;
    int zero_divides  = 0;
    int op_count[4]   = '{0, 0, 0, 0};
    int idle_cycles   = 0;
    int rx_hold_len   = 0;
    int rx_stall      = 0;
    bit no_idle       = 1'b0;

    byte_add_sub_mul_div_unit_top #(.WIDTH(WIDTH)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // expected result of one operation: wrap add/sub, shift-add multiply,
    // restoring divide with a (WIDTH+1)-bit partial remainder
    function automatic t_arith_res arith_result(t_func op, logic [WIDTH-1:0] a,
                                                logic [WIDTH-1:0] b);
        t_arith_res       r;
        logic [2*WIDTH-1:0] prod;
        logic [WIDTH:0]   rem;
        logic [WIDTH-1:0] quo;
        r    = '0;
        prod = '0;
        rem  = '0;
        quo  = '0;
        case (op)
            FUNC_ADD: begin
                r.lo = a + b;
            end
            FUNC_SUB: begin
                r.lo = a + (~b + 1'b1);
            end
            FUNC_MUL: begin
                for (int i = 0; i < WIDTH; i++) begin
                    if (a[i]) prod = prod + ({{WIDTH{1'b0}}, b} << i);
                end
                r.lo = prod[WIDTH-1:0];
                r.hi = prod[2*WIDTH-1:WIDTH];
            end
            default: begin
                for (int i = WIDTH - 1; i >= 0; i--) begin
                    rem = {rem[WIDTH-1:0], a[i]};
                    quo = quo << 1;
                    if (rem >= {1'b0, b}) begin
                        rem    = rem - {1'b0, b};
                        quo[0] = 1'b1;
                    end
                end
                r.lo = quo;
                r.hi = rem[WIDTH-1:0];
                r.dz = (b == '0);
            end
        endcase
        return r;
    endfunction

    // sender gap: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle) return 0;
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // operand biased toward the edges
    function automatic logic [WIDTH-1:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return WIDTH'(1);
            2: return '1;
            3: return WIDTH'(1) << $urandom_range(0, WIDTH - 1);
            default: return WIDTH'($urandom);
        endcase
    endfunction

    // offer one beat and hold it until accepted; starts and ends at a falling edge
    task automatic send_beat(t_func op, logic [WIDTH-1:0] a, logic [WIDTH-1:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= DATA_W'({b, a});
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
    endtask

    // wait for every expected result, then let the pipeline settle
    task automatic wait_drained();
        stop_sending();
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    task automatic send_random(int count, bit edgy);
        t_func op;
        logic [WIDTH-1:0] a;
        logic [WIDTH-1:0] b;
        for (int n = 0; n < count; n++) begin
            op = t_func'($urandom_range(0, 3));
            a  = edgy ? pick_operand() : WIDTH'($urandom);
            b  = edgy ? pick_operand() : WIDTH'($urandom);
            if (edgy && op == FUNC_DIV && $urandom_range(0, 3) == 0) b = '0;
            send_beat(op, a, b);
        end
    endtask

    // operand extremes, every operation, divide by zero
    task automatic test_directed();
        send_beat(FUNC_ADD, 8'd0,   8'd0);
        send_beat(FUNC_ADD, 8'd255, 8'd255);
        send_beat(FUNC_ADD, 8'd255, 8'd1);
        send_beat(FUNC_SUB, 8'd0,   8'd1);
        send_beat(FUNC_SUB, 8'd5,   8'd5);
        send_beat(FUNC_SUB, 8'd0,   8'd255);
        send_beat(FUNC_SUB, 8'd255, 8'd0);
        send_beat(FUNC_MUL, 8'd255, 8'd255);
        send_beat(FUNC_MUL, 8'd0,   8'd255);
        send_beat(FUNC_MUL, 8'd1,   8'd1);
        send_beat(FUNC_MUL, 8'd128, 8'd2);
        send_beat(FUNC_MUL, 8'd16,  8'd16);
        send_beat(FUNC_DIV, 8'd255, 8'd0);
        send_beat(FUNC_DIV, 8'd0,   8'd0);
        send_beat(FUNC_DIV, 8'd100, 8'd0);
        send_beat(FUNC_DIV, 8'd255, 8'd1);
        send_beat(FUNC_DIV, 8'd0,   8'd5);
        send_beat(FUNC_DIV, 8'd7,   8'd255);
        send_beat(FUNC_DIV, 8'd255, 8'd255);
        send_beat(FUNC_DIV, 8'd200, 8'd3);
        send_beat(FUNC_DIV, 8'd128, 8'd128);
        send_beat(FUNC_DIV, 8'd1,   8'd2);
        send_beat(FUNC_DIV, 8'd254, 8'd255);
        wait_drained();
    endtask

    task automatic test_random_mix();
        send_random(900, 1'b0);
    endtask

    // back to back on both sides
    task automatic test_full_rate();
        no_idle = 1'b1;
        send_random(300, 1'b0);
        no_idle = 1'b0;
    endtask

    // long output stall while the input keeps offering
    task automatic test_output_stall();
        no_idle     = 1'b1;
        rx_hold_len = 300;
        send_random(120, 1'b0);
        no_idle     = 1'b0;
    endtask

    // input pauses until all results are back
    task automatic test_drain_pause();
        send_random(50, 1'b0);
        wait_drained();
        send_random(50, 1'b1);
    endtask

    task automatic test_edge_operands();
        send_random(400, 1'b1);
    endtask

    // receiver: random stalls, or a long hold when requested
    always @(negedge i_clk) begin
        if (rx_hold_len > 0) begin
            rx_stall    = rx_hold_len;
            rx_hold_len = 0;
        end
        if (rx_stall > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall      = rx_stall - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if (!no_idle && $urandom_range(0, 3) == 0)
                rx_stall = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                         : $urandom_range(10, 40);
        end
    end

    // input beats queue expectations, output beats are checked against them
    always @(posedge i_clk) begin
        t_arith_res want;
        t_arith_res got;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(arith_result(t_func'(s_axis_tuser),
                                                        s_axis_tdata[WIDTH-1:0],
                                                        s_axis_tdata[2*WIDTH-1:WIDTH]));
                pending  = pending + 1;
                beats_in = beats_in + 1;
                op_count[s_axis_tuser] = op_count[s_axis_tuser] + 1;
                if (s_axis_tuser == FUNC_DIV && s_axis_tdata[2*WIDTH-1:WIDTH] == '0)
                    zero_divides = zero_divides + 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.lo = m_axis_tdata[WIDTH-1:0];
                got.hi = m_axis_tdata[2*WIDTH-1:WIDTH];
                got.dz = m_axis_tuser;
                results_seen = results_seen + 1;
                if (expected_results.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result with nothing expected: lo %0d hi %0d dz %0b",
                                 $realtime, got.lo, got.hi, got.dz);
                end else begin
                    want    = expected_results.pop_front();
                    pending = pending - 1;
                    if (got.lo !== want.lo || got.hi !== want.hi || got.dz !== want.dz) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: result %0d: lo %0d/%0d hi %0d/%0d dz %0b/%0b (exp/got)",
                                     $realtime, results_seen, want.lo, got.lo,
                                     want.hi, got.hi, want.dz, got.dz);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout after %0d cycles without a beat", idle_cycles);
                $display("byte_add_sub_mul_div_unit_top test failed");
                $finish;
            end
        end
    end

    // main sequence
    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FUNC_ADD;
        m_axis_tready = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random_mix();
        test_full_rate();
        test_output_stall();
        test_drain_pause();
        test_edge_operands();
        wait_drained();

        mismatches = mismatches + expected_results.size();
        $display("beats in %0d: add %0d, sub %0d, mul %0d, div %0d (%0d by zero)",
                 beats_in, op_count[FUNC_ADD], op_count[FUNC_SUB], op_count[FUNC_MUL],
                 op_count[FUNC_DIV], zero_divides);
        $display("checked %0d results over random gaps, full rate, output stall, drain pause",
                 results_seen);
        if (mismatches == 0) begin
            $display("byte_add_sub_mul_div_unit_top test passed");
        end else begin
            $display("byte_add_sub_mul_div_unit_top test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/bas_pkg.sv
hdl/bas_step.sv
hdl/byte_add_sub_mul_div_unit_top.sv
test/byte_add_sub_mul_div_unit_top_tb.sv
